FILE: src/rlepb_pkg.sv
package rlepb_pkg;

    // Header layout and segment table size
    localparam int MAX_SEGMENTS = 15;
    localparam int HEADER_BYTES = 64;
    localparam logic [31:0] LAST_HEADER_POS = 32'(HEADER_BYTES - 1);

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BYTES     = 1'b1;

    // PackBits control byte that does nothing (-128)
    localparam logic [7:0] CTRL_NOP = 8'h80;

    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_SHORT = 2'd2,
        KIND_COUNT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start_address;
        logic [7:0]  byte_value;
        logic [7:0]  run_length;
    } out_item_t;

    // Request to the run clipper: wanted positions, stride, room left in frame
    typedef struct packed {
        logic [7:0]  want;
        logic [3:0]  stride;
        logic [31:0] room;
    } clip_req_t;

endpackage

FILE: src/rlepb_clip.sv
module rlepb_clip
    import rlepb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  clip_req_t  req,
    output logic       done,
    output logic [7:0] run_len
);

    typedef enum logic [1:0] {
        C_IDLE   = 2'b01,
        C_SEARCH = 2'b10
    } clip_state_t;

    clip_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic [7:0]  len_reg, len_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  stride_reg, stride_next;
    logic [31:0] room_reg, room_next;

    logic [11:0] fast_prod;
    logic [6:0]  cand;
    logic [10:0] search_prod;

    // Span of the full run, and of the candidate length under test
    assign fast_prod   = (req.want - 8'd1) * req.stride;
    assign cand        = len_reg[6:0] | (7'd1 << bit_reg);
    assign search_prod = (cand - 7'd1) * stride_reg;

    // Take the full run when it fits, else search the largest length bit by bit
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        len_next    = len_reg;
        bit_next    = bit_reg;
        stride_next = stride_reg;
        room_next   = room_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    stride_next = req.stride;
                    room_next   = req.room;
                    if (req.stride == 4'd0 || {20'd0, fast_prod} < req.room)
                    begin
                        len_next  = req.want;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        len_next   = 8'd0;
                        bit_next   = 3'd6;
                        state_next = C_SEARCH;
                    end
                end
            end
            C_SEARCH:
            begin
                if ({21'd0, search_prod} < room_reg)
                begin
                    len_next = {1'b0, cand};
                end
                if (bit_reg == 3'd0)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold search operands and result
    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        bit_reg    <= bit_next;
        stride_reg <= stride_next;
        room_reg   <= room_next;
    end

    assign done    = done_reg;
    assign run_len = len_reg;

endmodule

FILE: src/rle_segment_packbits_decoder_unit.sv
// PackBits segment decoder for RLE-compressed objects. Each input word is one
// compressed byte; the first 64 bytes form the header (segment count and 15
// segment offsets, little-endian); the offsets are stored in a 15-entry
// offset memory with a registered read. Each later byte produces at most one
// run-write word (start address, value, length stepping by component_count,
// clipped to frame_bytes), and the byte flagged last produces one status word.
// Header bytes, bytes after a count mismatch and bytes with no segment left
// to decode are closed out when accepted. A decoded byte is accepted, compared
// with each later segment start it reaches (one compare per boundary it
// crosses, and one more unless it ends up in the last segment), checked
// against its segment start from the memory read, and, when it yields a run,
// sent through the clip and emit states, with the bit-serial length search
// when that run must be clipped at the frame end. A run or status word waits
// while the output register still holds an unaccepted word. The output
// register lets the next byte be taken while a word waits.
module rle_segment_packbits_decoder_unit
    import rlepb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_NEXT   = 6'b000010,
        S_CUR    = 6'b000100,
        S_CLIP   = 6'b001000,
        S_EMIT   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        HS_HEADER   = 3'b001,
        HS_DECODE   = 3'b010,
        HS_MISMATCH = 3'b100
    } hdr_t;

    typedef enum logic [2:0] {
        M_CONTROL = 3'b001,
        M_LITERAL = 3'b010,
        M_REPEAT  = 3'b100
    } mode_t;

    // Configuration
    logic [3:0]  cc_reg;
    logic [31:0] frame_reg;

    // Per-object state
    state_t      state_reg, state_next;
    hdr_t        hdr_reg, hdr_next;
    mode_t       mode_reg, mode_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  seg_idx_reg, seg_idx_next;
    logic [3:0]  seg_total_reg, seg_total_next;
    logic [31:0] dest_reg, dest_next;
    logic [7:0]  lit_reg, lit_next;
    logic [7:0]  rep_reg, rep_next;
    logic [3:0]  cnt_lo_reg, cnt_lo_next;
    logic        cnt_hi_nz_reg, cnt_hi_nz_next;
    logic [23:0] asm_reg, asm_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;
    logic        out_free;

    // Offset memory
    logic [31:0] mem [MAX_SEGMENTS];
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_rdata_reg;

    // Run clipper
    logic        clip_start;
    clip_req_t   clip_req;
    logic        clip_done;
    logic [7:0]  clip_len;

    // Helpers
    logic        fin;
    logic        fin_last;
    logic [3:0]  idx_adv;
    logic [11:0] emit_step;
    logic [32:0] emit_sum;

    function automatic logic has_next(input logic [3:0] idx, input logic [3:0] total);
        has_next = ({1'b0, idx} + 5'd1) < {1'b0, total};
    endfunction

    assign idx_adv   = seg_idx_reg + 4'd1;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_step = clip_len * cc_reg;
    assign emit_sum  = {1'b0, dest_reg} + 33'(emit_step);

    rlepb_clip u_clip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (clip_start),
        .req     (clip_req),
        .done    (clip_done),
        .run_len (clip_len)
    );

    // Sequence header capture, segment scan, decode and emit
    always_comb
    begin
        state_next     = state_reg;
        hdr_next       = hdr_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        seg_idx_next   = seg_idx_reg;
        seg_total_next = seg_total_reg;
        dest_next      = dest_reg;
        lit_next       = lit_reg;
        rep_next       = rep_reg;
        cnt_lo_next    = cnt_lo_reg;
        cnt_hi_nz_next = cnt_hi_nz_reg;
        asm_next       = asm_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[5:2] - 4'd1;
        mem_wdata      = {in_data.data_byte, asm_reg};
        mem_raddr      = has_next(seg_idx_reg, seg_total_reg) ? idx_adv : seg_idx_reg;
        clip_start     = 1'b0;
        clip_req.want  = 8'd1;
        clip_req.stride = cc_reg;
        clip_req.room  = frame_reg - dest_reg;
        fin            = 1'b0;
        fin_last       = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data.data_byte;
                    last_next = in_data.last_byte;
                    fin_last  = in_data.last_byte;
                    priority if (hdr_reg == HS_HEADER)
                    begin
                        // Collect the count word, then assemble and store offsets
                        if (pos_reg[31:2] == 30'd0)
                        begin
                            if (pos_reg[1:0] == 2'd0)
                            begin
                                cnt_lo_next    = in_data.data_byte[3:0];
                                cnt_hi_nz_next = |in_data.data_byte[7:4];
                            end
                            else
                            begin
                                cnt_hi_nz_next = cnt_hi_nz_reg | (|in_data.data_byte);
                            end
                        end
                        else
                        begin
                            asm_next = {in_data.data_byte, asm_reg[23:8]};
                            if (pos_reg[1:0] == 2'd3)
                            begin
                                mem_we = 1'b1;
                            end
                        end
                        // Check the segment count on the last header byte
                        if (pos_reg == LAST_HEADER_POS)
                        begin
                            if (!cnt_hi_nz_reg && cnt_lo_reg == cc_reg)
                            begin
                                hdr_next       = HS_DECODE;
                                seg_total_next = cnt_lo_reg;
                                seg_idx_next   = 4'd0;
                                dest_next      = 32'd0;
                                mode_next      = M_CONTROL;
                            end
                            else
                            begin
                                hdr_next = HS_MISMATCH;
                            end
                        end
                        fin = 1'b1;
                    end
                    else if (hdr_reg == HS_DECODE && seg_total_reg != 4'd0 &&
                             seg_idx_reg < seg_total_reg)
                    begin
                        state_next = has_next(seg_idx_reg, seg_total_reg) ? S_NEXT : S_CUR;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            S_NEXT:
            begin
                // Advance past every segment whose start is already reached
                if (pos_reg >= mem_rdata_reg)
                begin
                    seg_idx_next = idx_adv;
                    dest_next    = {28'd0, idx_adv};
                    mode_next    = M_CONTROL;
                    lit_next     = 8'd0;
                    rep_next     = 8'd0;
                    if (has_next(idx_adv, seg_total_reg))
                    begin
                        mem_raddr  = idx_adv + 4'd1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        mem_raddr  = idx_adv;
                        state_next = S_CUR;
                    end
                end
                else
                begin
                    mem_raddr  = seg_idx_reg;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                // Drop bytes before the segment start or once the frame is full
                if (pos_reg < mem_rdata_reg || dest_reg >= frame_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    unique case (mode_reg)
                        M_LITERAL:
                        begin
                            if (lit_reg <= 8'd1)
                            begin
                                lit_next  = 8'd0;
                                mode_next = M_CONTROL;
                            end
                            else
                            begin
                                lit_next = lit_reg - 8'd1;
                            end
                            clip_req.want = 8'd1;
                            clip_start    = 1'b1;
                            state_next    = S_CLIP;
                        end
                        M_REPEAT:
                        begin
                            rep_next      = 8'd0;
                            mode_next     = M_CONTROL;
                            clip_req.want = rep_reg;
                            clip_start    = 1'b1;
                            state_next    = S_CLIP;
                        end
                        M_CONTROL:
                        begin
                            if (!byte_reg[7])
                            begin
                                mode_next = M_LITERAL;
                                lit_next  = byte_reg + 8'd1;
                            end
                            else if (byte_reg != CTRL_NOP)
                            begin
                                mode_next = M_REPEAT;
                                rep_next  = ~byte_reg + 8'd2;
                            end
                            fin = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_CLIP:
            begin
                if (clip_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Send the run and step the destination, capped at the frame
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.kind          = KIND_RUN;
                    out_data_next.start_address = dest_reg;
                    out_data_next.byte_value    = byte_reg;
                    out_data_next.run_length    = clip_len;
                    dest_next = (emit_sum > {1'b0, frame_reg}) ? frame_reg : emit_sum[31:0];
                    fin = 1'b1;
                end
            end
            S_STATUS:
            begin
                // Send the status word and clear the object
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    unique case (hdr_reg)
                        HS_HEADER:   out_data_next.kind = KIND_SHORT;
                        HS_MISMATCH: out_data_next.kind = KIND_COUNT;
                        default:     out_data_next.kind = KIND_DONE;
                    endcase
                    out_data_next.start_address = 32'd0;
                    out_data_next.byte_value    = 8'd0;
                    out_data_next.run_length    = 8'd0;
                    pos_next       = 32'd0;
                    hdr_next       = HS_HEADER;
                    seg_idx_next   = 4'd0;
                    seg_total_next = 4'd0;
                    mode_next      = M_CONTROL;
                    lit_next       = 8'd0;
                    rep_next       = 8'd0;
                    dest_next      = 32'd0;
                    cnt_lo_next    = 4'd0;
                    cnt_hi_nz_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close out the byte: report status or advance the saturating position
        if (fin)
        begin
            if (fin_last)
            begin
                state_next = S_STATUS;
            end
            else
            begin
                state_next = S_IDLE;
                if (pos_reg != 32'hFFFF_FFFF)
                begin
                    pos_next = pos_reg + 32'd1;
                end
            end
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hdr_reg       <= HS_HEADER;
            mode_reg      <= M_CONTROL;
            pos_reg       <= 32'd0;
            seg_idx_reg   <= 4'd0;
            seg_total_reg <= 4'd0;
            dest_reg      <= 32'd0;
            lit_reg       <= 8'd0;
            rep_reg       <= 8'd0;
            cnt_lo_reg    <= 4'd0;
            cnt_hi_nz_reg <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cc_reg        <= 4'd1;
            frame_reg     <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_reg       <= hdr_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            seg_idx_reg   <= seg_idx_next;
            seg_total_reg <= seg_total_next;
            dest_reg      <= dest_next;
            lit_reg       <= lit_next;
            rep_reg       <= rep_next;
            cnt_lo_reg    <= cnt_lo_next;
            cnt_hi_nz_reg <= cnt_hi_nz_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COMPONENT_COUNT: cc_reg    <= cfg_data[3:0];
                    CFG_FRAME_BYTES:     frame_reg <= cfg_data;
                    default:             cc_reg    <= cc_reg;
                endcase
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        asm_reg      <= asm_next;
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
    end

    // Offset memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: dv/rle_segment_packbits_decoder_unit_test.sv
module rle_segment_packbits_decoder_unit_test
    import rlepb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DRAIN_CYCLES     = 40;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          RANDOM_BYTES     = 1100;
    localparam int          END_WAIT_LIMIT   = 20000;
    localparam int          PRINT_LIMIT      = 40;
    localparam int          REPEAT_BASE      = 257;
    localparam longint      CYCLE_LIMIT      = 1000000;

    typedef enum logic [1:0] {
        HDR_READING,
        HDR_DECODING,
        HDR_MISMATCH
    } header_state_t;

    typedef enum logic [1:0] {
        PB_CONTROL,
        PB_LITERAL,
        PB_REPEAT
    } packbits_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Register copies and per-object decoder state
    logic [3:0]     cur_components;
    logic [31:0]    cur_frame_bytes;
    logic [31:0]    seg_offset [MAX_SEGMENTS];
    logic [31:0]    obj_pos;
    header_state_t  hdr_state;
    int unsigned    seg_sel;
    packbits_mode_t pb_mode;
    int unsigned    literal_remaining;
    int unsigned    repeat_remaining;
    logic [31:0]    write_addr;
    logic [31:0]    header_count;
    int unsigned    active_segments;
    out_item_t      commands_due [$];

    // Object under construction
    logic [31:0]    plan_offsets [MAX_SEGMENTS];
    logic [7:0]     obj_body [$];

    bit             idle_on = 1'b1;
    bit             hold_request = 1'b0;
    int unsigned    mismatches = 0;
    int unsigned    words_checked = 0;
    int unsigned    run_words = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    useful_bytes = 0;
    int unsigned    status_count [4] = '{0, 0, 0, 0};
    longint         cycle_count = 0;

    rle_segment_packbits_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------

    function automatic void clear_object_state();
        foreach (seg_offset[i])
            seg_offset[i] = '0;
        obj_pos           = '0;
        hdr_state         = HDR_READING;
        seg_sel           = 0;
        pb_mode           = PB_CONTROL;
        literal_remaining = 0;
        repeat_remaining  = 0;
        write_addr        = '0;
        header_count      = '0;
        active_segments   = 0;
    endfunction

    // Queue a run write of up to want positions and advance the write address
    function automatic void queue_run(logic [7:0] val, int unsigned want);
        longint unsigned stride;
        longint unsigned dest;
        longint unsigned frame;
        longint unsigned len;
        longint unsigned room;
        longint unsigned nxt;
        out_item_t       w;
        stride = cur_components;
        dest   = write_addr;
        frame  = cur_frame_bytes;
        len    = want;
        if (dest >= frame || want == 0)
            return;
        // clip to the positions left in the frame
        if (stride != 0)
        begin
            room = (frame - dest + stride - 1) / stride;
            if (room < len)
                len = room;
        end
        w.kind          = KIND_RUN;
        w.start_address = write_addr;
        w.byte_value    = val;
        w.run_length    = 8'(len);
        commands_due.push_back(w);
        nxt = dest + len * stride;
        write_addr = (nxt > frame) ? 32'(frame) : 32'(nxt);
    endfunction

    function automatic void decode_segment_byte(logic [7:0] b);
        int unsigned want;
        if (active_segments == 0 || seg_sel >= active_segments || seg_sel >= MAX_SEGMENTS)
            return;
        // advance past every segment that has ended at this position
        while (seg_sel + 1 < active_segments && seg_sel + 1 < MAX_SEGMENTS &&
               obj_pos >= seg_offset[seg_sel + 1])
        begin
            seg_sel++;
            write_addr        = seg_sel;
            pb_mode           = PB_CONTROL;
            literal_remaining = 0;
            repeat_remaining  = 0;
        end
        // drop bytes before the segment start and once the frame is full
        if (obj_pos < seg_offset[seg_sel])
            return;
        if (write_addr >= cur_frame_bytes)
            return;
        case (pb_mode)
            PB_LITERAL:
            begin
                if (literal_remaining <= 1)
                begin
                    literal_remaining = 0;
                    pb_mode = PB_CONTROL;
                end
                else
                    literal_remaining--;
                queue_run(b, 1);
            end
            PB_REPEAT:
            begin
                want = repeat_remaining;
                repeat_remaining = 0;
                pb_mode = PB_CONTROL;
                queue_run(b, want);
            end
            default:
            begin
                if (b < CTRL_NOP)
                begin
                    pb_mode = PB_LITERAL;
                    literal_remaining = b + 1;
                end
                else if (b > CTRL_NOP)
                begin
                    pb_mode = PB_REPEAT;
                    repeat_remaining = REPEAT_BASE - b;
                end
            end
        endcase
    endfunction

    // Work out the words caused by one accepted compressed byte
    function automatic void track_compressed_byte(logic [7:0] b, logic last);
        int unsigned slot;
        int unsigned shift;
        out_item_t   w;
        if (hdr_state != HDR_MISMATCH)
            useful_bytes++;
        if (hdr_state == HDR_READING)
        begin
            // gather the little-endian count word and offset table
            if (obj_pos < 4)
            begin
                shift = 8 * obj_pos;
                header_count = (shift == 0 ? 32'd0 : header_count) | (32'(b) << shift);
            end
            else if (obj_pos < HEADER_BYTES)
            begin
                slot  = (obj_pos - 4) >> 2;
                shift = 8 * ((obj_pos - 4) & 3);
                seg_offset[slot] = (shift == 0 ? 32'd0 : seg_offset[slot]) | (32'(b) << shift);
            end
            if (obj_pos == LAST_HEADER_POS)
            begin
                if (header_count == 32'(cur_components) && header_count <= MAX_SEGMENTS)
                begin
                    hdr_state       = HDR_DECODING;
                    active_segments = header_count;
                    seg_sel         = 0;
                    write_addr      = '0;
                    pb_mode         = PB_CONTROL;
                end
                else
                    hdr_state = HDR_MISMATCH;
            end
        end
        else if (hdr_state == HDR_DECODING)
            decode_segment_byte(b);

        // close the object with one status word
        if (last)
        begin
            w = '0;
            case (hdr_state)
                HDR_READING:  w.kind = KIND_SHORT;
                HDR_MISMATCH: w.kind = KIND_COUNT;
                default:      w.kind = KIND_DONE;
            endcase
            commands_due.push_back(w);
            status_count[int'(w.kind)]++;
            clear_object_state();
        end
        else if (obj_pos != 32'hFFFF_FFFF)
            obj_pos++;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch at word %0d, %s: expected %0h, got %0h",
                     $realtime, words_checked, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : word_checker
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            words_checked++;
            if (out_data.kind == KIND_RUN)
                run_words++;
            if (commands_due.size() == 0)
                report_mismatch("word with nothing outstanding", '0, 64'(out_data));
            else
            begin
                want = commands_due.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch("kind", 64'(want.kind), 64'(out_data.kind));
                if (out_data.start_address !== want.start_address)
                    report_mismatch("start_address", 64'(want.start_address),
                                    64'(out_data.start_address));
                if (out_data.byte_value !== want.byte_value)
                    report_mismatch("byte_value", 64'(want.byte_value),
                                    64'(out_data.byte_value));
                if (out_data.run_length !== want.run_length)
                    report_mismatch("run_length", 64'(want.run_length),
                                    64'(out_data.run_length));
            end
        end
    end

    // Drive out_ready: random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        int unsigned stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 6);
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Offer one compressed byte and hold it until accepted
    task automatic send_word(logic [7:0] b, logic last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        track_compressed_byte(b, last);
        bytes_sent++;
    endtask

    // Let every outstanding word out, then the block's worst-case latency
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (commands_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_block(logic [3:0] comps, logic [31:0] frame);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COMPONENT_COUNT;
        cfg_data  <= 32'(comps);
        @(posedge clk);
        cfg_index <= CFG_FRAME_BYTES;
        cfg_data  <= frame;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_components  = comps;
        cur_frame_bytes = frame;
    endtask

    function automatic void clear_plan();
        foreach (plan_offsets[i])
            plan_offsets[i] = '1;
        obj_body.delete();
    endfunction

    // Send header and body, keeping only keep_bytes of them when nonzero
    task automatic send_object(logic [31:0] count_word, int unsigned keep_bytes);
        logic [7:0]  stream [$];
        int unsigned total;
        for (int k = 0; k < 4; k++)
            stream.push_back(count_word[8*k +: 8]);
        for (int s = 0; s < MAX_SEGMENTS; s++)
            for (int k = 0; k < 4; k++)
                stream.push_back(plan_offsets[s][8*k +: 8]);
        foreach (obj_body[i])
            stream.push_back(obj_body[i]);
        total = stream.size();
        if (keep_bytes != 0 && keep_bytes < total)
            total = keep_bytes;
        for (int unsigned i = 0; i < total; i++)
            send_word(stream[i], i == total - 1);
    endtask

    // Append random PackBits packets; optionally end inside a packet
    function automatic void append_packbits(int unsigned packets, bit cut_tail);
        int unsigned n;
        int unsigned pick;
        logic [7:0]  ctrl;
        repeat (packets)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                case ($urandom_range(0, 29))
                    0:       n = 0;
                    1:       n = 127;
                    2:       n = $urandom_range(0, 127);
                    default: n = $urandom_range(0, 7);
                endcase
                obj_body.push_back(8'(n));
                repeat (n + 1) obj_body.push_back(8'($urandom));
            end
            else if (pick < 9)
            begin
                if ($urandom_range(0, 5) == 0)
                    ctrl = $urandom_range(0, 1) ? 8'd129 : 8'd255;
                else
                    ctrl = 8'($urandom_range(129, 255));
                obj_body.push_back(ctrl);
                obj_body.push_back(8'($urandom));
            end
            else
                obj_body.push_back(CTRL_NOP);
        end
        if (cut_tail)
        begin
            if ($urandom_range(0, 1))
                obj_body.push_back(8'($urandom_range(129, 255)));
            else
            begin
                n = $urandom_range(1, 9);
                obj_body.push_back(8'(n));
                repeat ($urandom_range(0, n)) obj_body.push_back(8'($urandom));
            end
        end
    endfunction

    // Mostly well-formed objects; some short, some with a bad count,
    // scrambled offsets, or data cut off inside a segment
    task automatic send_random_object();
        int unsigned flavor;
        int unsigned keep;
        logic [31:0] count_word;
        flavor = $urandom_range(0, 9);
        obj_body.delete();
        foreach (plan_offsets[i])
            plan_offsets[i] = $urandom;
        for (int unsigned s = 0; s < cur_components; s++)
        begin
            plan_offsets[s] = HEADER_BYTES + obj_body.size();
            append_packbits($urandom_range(0, 4), $urandom_range(0, 4) == 0);
        end
        count_word = 32'(cur_components);
        keep = 0;
        case (flavor)
            0: keep = $urandom_range(1, HEADER_BYTES - 1);
            1:
            begin
                do
                    count_word = $urandom_range(0, 1) ? 32'($urandom_range(0, 16)) : $urandom;
                while (count_word == 32'(cur_components));
            end
            2:
            begin
                for (int unsigned s = 0; s < cur_components; s++)
                    case ($urandom_range(0, 3))
                        0: plan_offsets[s] = $urandom_range(0, HEADER_BYTES - 1);
                        1: plan_offsets[s] = $urandom_range(HEADER_BYTES,
                                                            HEADER_BYTES + obj_body.size() + 8);
                        2: plan_offsets[s] = $urandom;
                        default: ;
                    endcase
            end
            3:
            begin
                if (obj_body.size() != 0)
                    keep = HEADER_BYTES + $urandom_range(1, obj_body.size());
            end
            default: ;
        endcase
        send_object(count_word, keep);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Objects that end inside the header
    task automatic test_short_object();
        program_block(4'd1, 32'd64);
        clear_plan();
        send_object(32'd1, 5);
        send_word(8'h00, 1'b1);
        send_object(32'd1, HEADER_BYTES - 1);
    endtask

    // Wrong segment count, and a header-only object with the right count
    task automatic test_count_mismatch();
        clear_plan();
        plan_offsets[0] = HEADER_BYTES;
        obj_body = '{8'h01, 8'h12, 8'h34};
        send_object(32'd2, 0);
        obj_body.delete();
        send_object(32'd1, 0);
    endtask

    // Shortest literal, longest and shortest repeat, a no-op control, repeat cut off
    task automatic test_packbits_controls();
        program_block(4'd1, 32'hFFFF_FFFF);
        clear_plan();
        plan_offsets[0] = HEADER_BYTES;
        obj_body = '{8'h00, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h7F, CTRL_NOP,
                     8'h81, 8'hAA, 8'hFF, 8'h55, 8'h81};
        send_object(32'd1, 0);
    endtask

    // Runs clipped at a small frame, an empty segment, two boundaries at once
    task automatic test_frame_clipping();
        program_block(4'd3, 32'd10);
        clear_plan();
        plan_offsets[0] = HEADER_BYTES;
        plan_offsets[1] = HEADER_BYTES + 4;
        plan_offsets[2] = HEADER_BYTES + 4;
        obj_body = '{8'h81, 8'h11, 8'h00, 8'h22, 8'hFE, 8'h66, 8'h00, 8'h77};
        send_object(32'd3, 0);
    endtask

    // Offset inside the header, then offsets that go backwards
    task automatic test_segment_offsets();
        program_block(4'd2, 32'hFFFF_FFFF);
        clear_plan();
        plan_offsets[0] = 32'd10;
        plan_offsets[1] = HEADER_BYTES + 4;
        obj_body = '{8'h01, 8'hA1, 8'hA2, CTRL_NOP, 8'hFD, 8'h5A};
        send_object(32'd2, 0);
        plan_offsets[0] = HEADER_BYTES + 8;
        plan_offsets[1] = HEADER_BYTES + 2;
        obj_body = '{8'h00, 8'h01, 8'h00, 8'hC3, CTRL_NOP, CTRL_NOP, CTRL_NOP, CTRL_NOP,
                     8'h00, 8'hEE};
        send_object(32'd2, 0);
    endtask

    // Zero components with a zero count, then an empty frame
    task automatic test_degenerate_config();
        program_block(4'd0, 32'd100);
        clear_plan();
        plan_offsets[0] = HEADER_BYTES;
        obj_body = '{8'h81, 8'h01, 8'h00, 8'h02};
        send_object(32'd0, 0);
        program_block(4'd1, 32'd0);
        send_object(32'd1, 0);
    endtask

    // Hold the result side for a long stretch while literals keep coming
    task automatic test_backpressure();
        program_block(4'd1, 32'hFFFF_FFFF);
        clear_plan();
        plan_offsets[0] = HEADER_BYTES;
        repeat (3)
        begin
            obj_body.push_back(8'd63);
            repeat (64) obj_body.push_back(8'($urandom));
        end
        hold_request = 1'b1;
        send_object(32'd1, 0);
    endtask

    task automatic test_random_objects();
        int unsigned start_bytes;
        logic [3:0]  comps;
        logic [31:0] frame;
        bit          first;
        start_bytes = useful_bytes;
        first = 1'b1;
        while (useful_bytes - start_bytes < RANDOM_BYTES)
        begin
            // run the tail with no idling on either side
            if (useful_bytes - start_bytes > RANDOM_BYTES * 4 / 5)
                idle_on = 1'b0;
            if (first || $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 19))
                    0:       comps = 4'd0;
                    1, 2:    comps = 4'd1;
                    3:       comps = 4'd15;
                    4, 5, 6, 7, 8, 9: comps = 4'($urandom_range(1, 4));
                    default: comps = 4'($urandom_range(1, 15));
                endcase
                case ($urandom_range(0, 11))
                    0:       frame = 32'd0;
                    1, 2:    frame = 32'hFFFF_FFFF;
                    3, 4:    frame = $urandom;
                    5, 6:    frame = $urandom_range(1, 40);
                    default: frame = $urandom_range(1, 400);
                endcase
                program_block(comps, frame);
                first = 1'b0;
            end
            send_random_object();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin : test_sequence
        int unsigned guard;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cur_components  = 4'd1;
        cur_frame_bytes = '0;
        clear_object_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_short_object();
        test_count_mismatch();
        test_packbits_controls();
        test_frame_clipping();
        test_segment_offsets();
        test_degenerate_config();
        test_backpressure();
        test_random_objects();

        // drain, bounded
        in_valid <= 1'b0;
        guard = 0;
        while (commands_due.size() != 0 && guard < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (commands_due.size() != 0)
            report_mismatch("words never produced", '0, 64'(commands_due.size()));

        $display("Covered %0d objects: %0d decoded, %0d cut short, %0d with a wrong count.",
                 status_count[KIND_DONE] + status_count[KIND_SHORT] + status_count[KIND_COUNT],
                 status_count[KIND_DONE], status_count[KIND_SHORT], status_count[KIND_COUNT]);
        $display("Sent %0d compressed bytes; compared %0d words, %0d of them run writes.",
                 bytes_sent, words_checked, run_words);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d words outstanding",
                 cycle_count, commands_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/rlepb_pkg.sv
src/rlepb_clip.sv
src/rle_segment_packbits_decoder_unit.sv
dv/rle_segment_packbits_decoder_unit_test.sv
